@@ sv/length_prefixed_frame_checker_unit_defines.svh @@
// Assertion macros for the length-prefixed frame checker.
`ifndef LENGTH_PREFIXED_FRAME_CHECKER_UNIT_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define LPFC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("frame checker: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define LPFC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("frame checker: next-cycle check failed");

`endif

@@ sv/lpfc_pkg.sv @@
// Types and constants of the length-prefixed frame checker.
package lpfc_pkg;

    // Last header byte index, minimum frame length in bytes, and Adler-32 modulus
    localparam logic [1:0]  HDR_LAST       = 2'd3;
    localparam logic [31:0] MIN_STRUCT_LEN = 32'd8;
    localparam logic [16:0] ADLER_MOD      = 17'd65521;

    // Expected tag bytes, "RPC0"
    localparam logic [7:0] FRAME_TAG [4] = '{8'h52, 8'h50, 8'h43, 8'h30};

    // Configuration register indexes
    localparam logic [1:0] CFG_MIN_LEN = 2'd0;
    localparam logic [1:0] CFG_MAX_LEN = 2'd1;

    // Configuration reset values
    localparam logic [30:0] MIN_LEN_RESET = 31'd8;
    localparam logic [30:0] MAX_LEN_RESET = 31'd67108864;

    // Frame report codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_BAD_SUM = 2'd2;
    localparam logic [1:0] ST_BAD_TAG = 2'd3;

    // Parser phase
    typedef enum logic [4:0] {
        PH_LEN  = 5'b00001,
        PH_TAG  = 5'b00010,
        PH_PAY  = 5'b00100,
        PH_TRL  = 5'b01000,
        PH_HALT = 5'b10000
    } phase_t;

    // Result side-band, payload_valid in bit 0
    typedef struct packed {
        logic [1:0] frame_status;
        logic       frame_done;
        logic       payload_valid;
    } result_user_t;

endpackage

@@ sv/length_prefixed_frame_checker_unit.sv @@
// Length-prefixed frame checker: length check, tag check, Adler-32 trailer check.
// Results are registered: a result appears on the master side in the cycle after its byte's transfer.
// Throughput: one byte per cycle while the output register is empty or draining; the Adler-32 update is combinational.
// A single output register decouples the sides; a new byte is taken while it drains.
// Reset (aresetn low, synchronous): parser back to length phase, output empty,
// length limits back to 8 and 67108864. An invalid length halts the parser until reset.
`include "length_prefixed_frame_checker_unit_defines.svh"

module length_prefixed_frame_checker_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_wdata,
    // received byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,
    output logic [2:0]  m_tuser     // [0] payload_valid, [2:1] frame_status
);

    // Registers
    logic [30:0]           min_len_reg, min_len_next;
    logic [30:0]           max_len_reg, max_len_next;
    lpfc_pkg::phase_t      phase_reg, phase_next;
    logic [1:0]            cnt_reg, cnt_next;
    logic [31:0]           len_reg, len_next;
    logic [30:0]           remain_reg, remain_next;
    logic [15:0]           adler_lo_reg, adler_lo_next;
    logic [15:0]           adler_hi_reg, adler_hi_next;
    logic                  tag_ok_reg, tag_ok_next;
    logic [23:0]           trl_reg, trl_next;
    logic                  m_valid_reg, m_valid_next;
    logic [7:0]            m_data_reg, m_data_next;
    lpfc_pkg::result_user_t m_user_reg, m_user_next;

    // Working signals
    logic                  in_xfer;
    logic                  emit;
    logic [7:0]            emit_byte;
    lpfc_pkg::result_user_t emit_user;
    logic [31:0]           len_shift;
    logic                  len_ok;
    logic [16:0]           lo_sum, lo_mod, hi_sum, hi_mod;
    logic                  last_hdr;

    assign s_tready = !m_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;
    assign last_hdr = (cnt_reg == lpfc_pkg::HDR_LAST);

    // Length word as it stands after this byte, and its range check
    assign len_shift = {len_reg[23:0], s_tdata};
    assign len_ok = !len_shift[31] && (len_shift >= lpfc_pkg::MIN_STRUCT_LEN)
                    && (len_shift[30:0] >= min_len_reg) && (len_shift[30:0] <= max_len_reg);

    // Adler-32 step: both sums reduced by one conditional subtract
    always_comb begin
        lo_sum = {1'b0, adler_lo_reg} + {9'd0, s_tdata};
        lo_mod = (lo_sum >= lpfc_pkg::ADLER_MOD) ? lo_sum - lpfc_pkg::ADLER_MOD : lo_sum;
        hi_sum = {1'b0, adler_hi_reg} + {1'b0, lo_mod[15:0]};
        hi_mod = (hi_sum >= lpfc_pkg::ADLER_MOD) ? hi_sum - lpfc_pkg::ADLER_MOD : hi_sum;
    end

    // Configuration writes
    always_comb begin
        min_len_next = min_len_reg;
        max_len_next = max_len_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                lpfc_pkg::CFG_MIN_LEN: min_len_next = cfg_wdata;
                lpfc_pkg::CFG_MAX_LEN: max_len_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    // Frame parser
    always_comb begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        len_next      = len_reg;
        remain_next   = remain_reg;
        adler_lo_next = adler_lo_reg;
        adler_hi_next = adler_hi_reg;
        tag_ok_next   = tag_ok_reg;
        trl_next      = trl_reg;
        emit          = 1'b0;
        emit_byte     = 8'd0;
        emit_user     = '0;
        if (in_xfer) begin
            unique case (phase_reg)
                lpfc_pkg::PH_LEN: begin
                    len_next = len_shift;
                    cnt_next = cnt_reg + 2'd1;
                    if (last_hdr) begin
                        if (len_ok) begin
                            phase_next = lpfc_pkg::PH_TAG;
                        end else begin
                            phase_next             = lpfc_pkg::PH_HALT;
                            emit                   = 1'b1;
                            emit_user.frame_done   = 1'b1;
                            emit_user.frame_status = lpfc_pkg::ST_BAD_LEN;
                        end
                    end
                end
                lpfc_pkg::PH_TAG: begin
                    adler_lo_next = lo_mod[15:0];
                    adler_hi_next = hi_mod[15:0];
                    tag_ok_next   = tag_ok_reg && (s_tdata == lpfc_pkg::FRAME_TAG[cnt_reg]);
                    cnt_next      = cnt_reg + 2'd1;
                    if (last_hdr) begin
                        // payload length; the length check keeps this non-negative
                        remain_next = len_reg[30:0] - lpfc_pkg::MIN_STRUCT_LEN[30:0];
                        phase_next  = (len_reg == lpfc_pkg::MIN_STRUCT_LEN) ?
                                      lpfc_pkg::PH_TRL : lpfc_pkg::PH_PAY;
                    end
                end
                lpfc_pkg::PH_PAY: begin
                    adler_lo_next           = lo_mod[15:0];
                    adler_hi_next           = hi_mod[15:0];
                    remain_next             = remain_reg - 31'd1;
                    emit                    = 1'b1;
                    emit_byte               = s_tdata;
                    emit_user.payload_valid = 1'b1;
                    if (remain_reg == 31'd1) begin
                        phase_next = lpfc_pkg::PH_TRL;
                    end
                end
                lpfc_pkg::PH_TRL: begin
                    trl_next = {trl_reg[15:0], s_tdata};
                    cnt_next = cnt_reg + 2'd1;
                    if (last_hdr) begin
                        emit                 = 1'b1;
                        emit_user.frame_done = 1'b1;
                        // checksum takes precedence over the tag
                        if ({adler_hi_reg, adler_lo_reg} != {trl_reg, s_tdata}) begin
                            emit_user.frame_status = lpfc_pkg::ST_BAD_SUM;
                        end else if (!tag_ok_reg) begin
                            emit_user.frame_status = lpfc_pkg::ST_BAD_TAG;
                        end else begin
                            emit_user.frame_status = lpfc_pkg::ST_OK;
                        end
                        // fresh frame
                        phase_next    = lpfc_pkg::PH_LEN;
                        len_next      = 32'd0;
                        adler_lo_next = 16'd1;
                        adler_hi_next = 16'd0;
                        tag_ok_next   = 1'b1;
                        trl_next      = 24'd0;
                    end
                end
                lpfc_pkg::PH_HALT: ;
                default: phase_next = lpfc_pkg::PH_HALT;
            endcase
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (in_xfer && emit) begin
            m_valid_next = 1'b1;
            m_data_next  = emit_byte;
            m_user_next  = emit_user;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // State update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg  <= lpfc_pkg::MIN_LEN_RESET;
            max_len_reg  <= lpfc_pkg::MAX_LEN_RESET;
            phase_reg    <= lpfc_pkg::PH_LEN;
            cnt_reg      <= 2'd0;
            len_reg      <= 32'd0;
            adler_lo_reg <= 16'd1;
            adler_hi_reg <= 16'd0;
            tag_ok_reg   <= 1'b1;
            trl_reg      <= 24'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            min_len_reg  <= min_len_next;
            max_len_reg  <= max_len_next;
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            len_reg      <= len_next;
            adler_lo_reg <= adler_lo_next;
            adler_hi_reg <= adler_hi_next;
            tag_ok_reg   <= tag_ok_next;
            trl_reg      <= trl_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        remain_reg <= remain_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_user_reg.frame_done;
    assign m_tuser  = {m_user_reg.frame_status, m_user_reg.payload_valid};

    // Checks
    `LPFC_ASSERT_IMPL(a_result_kind, aclk, aresetn, m_valid_reg, m_user_reg.payload_valid != m_user_reg.frame_done)
    `LPFC_ASSERT_NEXT(a_halt_sticks, aclk, aresetn, phase_reg == lpfc_pkg::PH_HALT, phase_reg == lpfc_pkg::PH_HALT)
    `LPFC_ASSERT_NEXT(a_halt_silent, aclk, aresetn, (phase_reg == lpfc_pkg::PH_HALT) && !m_valid_reg, !m_valid_reg)
    `LPFC_ASSERT_IMPL(a_payload_zero_ok, aclk, aresetn, m_valid_reg && m_user_reg.payload_valid, m_user_reg.frame_status == lpfc_pkg::ST_OK)

endmodule
